FILE: design/locator_great_circle_distance_assert.svh
// Assertion macros shared by the modules of the locator distance block.
`ifndef LOCATOR_GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define LOCATOR_GREAT_CIRCLE_DISTANCE_ASSERT_SVH

// Checks a property on every rising edge of clk outside reset.
`define LGCD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lgcd assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define LGCD_ASSERT_NEXT(label, ante, cons) \
    `LGCD_ASSERT(label, (ante) |=> (cons))

`endif

FILE: design/lgcd_pkg.sv
// ----------------------------------------------------------------------------
// lgcd_pkg
// Types, constants and the arctangent table of the locator distance block.
// ----------------------------------------------------------------------------
package lgcd_pkg;

    localparam int DEF_CORDIC_STEPS    = 24;
    localparam int DEF_ANGLE_FRAC_BITS = 20;

    localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
    localparam longint unsigned PI_Q30 = (PI_Q60 + (64'd1 << 29)) >> 30;
    localparam longint unsigned DEG2RAD_Q32 = (PI_Q60 / 180 + (64'd1 << 27)) >> 28;
    localparam longint unsigned GAIN_INV_Q30 = 652032874;

    localparam logic [7:0] CHAR_A     = 8'd65;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] LON_FIRST  = 8'd65;
    localparam logic [7:0] LON_LAST   = 8'd82;
    localparam logic [7:0] LAT_FIRST  = 8'd66;
    localparam logic [7:0] LAT_LAST   = 8'd81;
    localparam logic [7:0] DIGIT_LAST = 8'd57;

    typedef enum logic [7:0] {
        CFG_LON_FIELD  = 8'd0,
        CFG_LAT_FIELD  = 8'd1,
        CFG_LON_SQUARE = 8'd2,
        CFG_LAT_SQUARE = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] target_lon_field_char;
        logic [7:0] target_lat_field_char;
        logic [7:0] target_lon_square_char;
        logic [7:0] target_lat_square_char;
    } target_t;

    typedef struct packed {
        logic [13:0] distance_miles;
        logic        locator_valid;
    } result_t;

    typedef logic [31:0] atan_tab_t [0:31];

    // Restoring long division, evaluated only while the table is built.
    function automatic longint unsigned table_udiv(
        input longint unsigned num,
        input longint unsigned den
    );
        longint unsigned quo;
        longint unsigned rem;
        int              b;
        quo = 0;
        rem = 0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic atan_tab_t atan_table_build();
        atan_tab_t       tab;
        longint unsigned acc;
        longint unsigned term;
        int unsigned     i;
        int unsigned     k;
        for (i = 0; i < 32; i++)
        begin
            if (i == 0)
            begin
                tab[i] = 32'((PI_Q60 + (64'd1 << 31)) >> 32);
            end
            else
            begin
                acc = 0;
                for (k = 0; 62 >= i * (2 * k + 1); k++)
                begin
                    term = table_udiv(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
                    acc  = k[0] ? acc - term : acc + term;
                end
                tab[i] = 32'((acc + (64'd1 << 31)) >> 32);
            end
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = atan_table_build();

endpackage

FILE: design/lgcd_fifo.sv
// ----------------------------------------------------------------------------
// lgcd_fifo
// Small register queue with a combinational head, used between the parts.
// ----------------------------------------------------------------------------
`include "locator_great_circle_distance_assert.svh"

module lgcd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `LGCD_ASSERT(count_in_range, count_reg <= CW'(DEPTH))
    `LGCD_ASSERT_NEXT(count_up, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)
    `LGCD_ASSERT_NEXT(count_down, do_pop && !do_push, count_reg == $past(count_reg) - 1'b1)

endmodule

FILE: design/lgcd_front.sv
// ----------------------------------------------------------------------------
// lgcd_front
// Holds the station registers, validates and decodes each target locator.
// ----------------------------------------------------------------------------
module lgcd_front #(
    parameter int ANGLE_FRAC_BITS = lgcd_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int DEG_W           = ANGLE_FRAC_BITS + 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lgcd_pkg::target_t      target,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [7:0]             cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   mid_full,
    output logic                   mid_push,
    output logic [3*DEG_W:0]       mid_data
);
    import lgcd_pkg::*;

    localparam longint DEG_ONE = longint'(1) << ANGLE_FRAC_BITS;
    localparam longint LAT_OFF = (23 * DEG_ONE + 24) / 48;
    localparam longint LON_OFF = (23 * DEG_ONE + 12) / 24;

    logic [7:0] st_lon_field_reg;
    logic [7:0] st_lat_field_reg;
    logic [7:0] st_lon_square_reg;
    logic [7:0] st_lat_square_reg;

    logic                    valid;
    logic signed [DEG_W-1:0] slat;
    logic signed [DEG_W-1:0] slon;
    logic signed [DEG_W-1:0] tlat;
    logic signed [DEG_W-1:0] tlon;
    logic signed [DEG_W-1:0] dlon;

    function automatic logic signed [DEG_W-1:0] decode_deg(
        input logic [7:0] letter,
        input logic [7:0] digit,
        input logic       is_lon
    );
        logic [7:0]         l;
        logic [7:0]         d;
        logic signed [15:0] whole;
        l = letter - CHAR_A;
        d = digit - CHAR_ZERO;
        if (is_lon)
        begin
            whole = $signed({8'd0, l}) * 16'sd20 + $signed({8'd0, d}) * 16'sd2 - 16'sd180;
            return (DEG_W'(whole) <<< ANGLE_FRAC_BITS) + DEG_W'(LON_OFF);
        end
        whole = $signed({8'd0, l}) * 16'sd10 + $signed({8'd0, d}) - 16'sd90;
        return (DEG_W'(whole) <<< ANGLE_FRAC_BITS) + DEG_W'(LAT_OFF);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_lon_field_reg  <= CHAR_A;
            st_lat_field_reg  <= CHAR_A;
            st_lon_square_reg <= CHAR_ZERO;
            st_lat_square_reg <= CHAR_ZERO;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LON_FIELD:  st_lon_field_reg  <= cfg_data;
                CFG_LAT_FIELD:  st_lat_field_reg  <= cfg_data;
                CFG_LON_SQUARE: st_lon_square_reg <= cfg_data;
                CFG_LAT_SQUARE: st_lat_square_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        valid = (target.target_lon_field_char inside {[LON_FIRST:LON_LAST]})
             && (target.target_lat_field_char inside {[LAT_FIRST:LAT_LAST]})
             && (target.target_lon_square_char inside {[CHAR_ZERO:DIGIT_LAST]})
             && (target.target_lat_square_char inside {[CHAR_ZERO:DIGIT_LAST]});
        slat = decode_deg(st_lat_field_reg, st_lat_square_reg, 1'b0);
        slon = decode_deg(st_lon_field_reg, st_lon_square_reg, 1'b1);
        tlat = decode_deg(target.target_lat_field_char, target.target_lat_square_char, 1'b0);
        tlon = decode_deg(target.target_lon_field_char, target.target_lon_square_char, 1'b1);
        dlon = tlon - slon;
    end

    assign mid_push = push && !mid_full;
    assign mid_data = {valid, slat, tlat, dlon};

endmodule

FILE: design/lgcd_back.sv
// ----------------------------------------------------------------------------
// lgcd_back
// Sequencer over one shared CORDIC, multiplier and square-root unit that
// turns a decoded locator pair into a distance in miles.
// ----------------------------------------------------------------------------
`include "locator_great_circle_distance_assert.svh"

module lgcd_back #(
    parameter int CORDIC_STEPS    = lgcd_pkg::DEF_CORDIC_STEPS,
    parameter int ANGLE_FRAC_BITS = lgcd_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int DEG_W           = ANGLE_FRAC_BITS + 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mid_empty,
    input  logic [3*DEG_W:0]    mid_data,
    output logic                mid_pop,
    input  logic                out_full,
    output logic                out_push,
    output lgcd_pkg::result_t   out_item
);
    import lgcd_pkg::*;

    localparam int CW = 34;
    localparam int AW = ANGLE_FRAC_BITS + 9;
    localparam int PW = AW + 28;
    localparam int SW = $clog2(CORDIC_STEPS);
    localparam logic signed [DEG_W-1:0] FULL_DEG = DEG_W'(360) <<< ANGLE_FRAC_BITS;
    localparam logic signed [DEG_W-1:0] HALF_DEG = DEG_W'(180) <<< ANGLE_FRAC_BITS;
    localparam logic signed [DEG_W-1:0] QUAR_DEG = DEG_W'(90) <<< ANGLE_FRAC_BITS;
    localparam logic signed [DEG_W-1:0] BIAS_DEG = DEG_W'(11520) <<< ANGLE_FRAC_BITS;
    localparam logic signed [27:0]      D2R      = 28'(DEG2RAD_Q32);
    localparam logic signed [CW-1:0]    ONE      = CW'(64'd1 << 30);
    localparam logic signed [CW-1:0]    PI_S     = CW'(PI_Q30);
    localparam logic signed [CW-1:0]    GAIN     = CW'(GAIN_INV_Q30);

    typedef enum logic [4:0] {
        S_IDLE, S_WRAP, S_FOLD, S_CONV, S_ZINIT, S_ROT, S_STORE,
        S_MUL_A, S_MUL_B1, S_MUL_B2, S_SUM, S_SQ, S_SQRT, S_VEC,
        S_ANG, S_MILES, S_DIV, S_DONE
    } state_t;

    state_t                  state_reg;
    logic [2:0]              k_reg;
    logic [SW-1:0]           cnt_reg;
    logic [1:0]              sel_reg;
    logic                    flip_reg;
    logic                    valid_reg;
    logic signed [DEG_W-1:0] r_reg;
    logic signed [DEG_W-1:0] tlat_reg;
    logic signed [DEG_W-1:0] dlon_reg;
    logic signed [AW-1:0]    fa_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [CW-1:0]    x_reg;
    logic signed [CW-1:0]    y_reg;
    logic signed [CW-1:0]    z_reg;
    logic signed [CW-1:0]    s_reg [3];
    logic signed [CW-1:0]    c_reg [3];
    logic signed [CW-1:0]    a_reg;
    logic signed [CW-1:0]    b_reg;
    logic signed [CW-1:0]    arg_reg;
    logic [61:0]             n_reg;
    logic [61:0]             root_reg;
    logic [4:0]              p_reg;
    logic [31:0]             ang_reg;
    logic [16:0]             v_reg;
    logic [13:0]             dist_reg;

    logic                    e_valid;
    logic signed [DEG_W-1:0] e_slat;
    logic signed [DEG_W-1:0] e_tlat;
    logic signed [DEG_W-1:0] e_dlon;
    logic signed [DEG_W-1:0] wrap_thr;
    logic signed [DEG_W-1:0] wrapped;
    logic signed [DEG_W-1:0] folded;
    logic                    fold_flip;
    logic                    dir;
    logic signed [CW-1:0]    xs;
    logic signed [CW-1:0]    ys;
    logic signed [CW-1:0]    atan_v;
    logic signed [CW-1:0]    x_step;
    logic signed [CW-1:0]    y_step;
    logic signed [CW-1:0]    z_step;
    logic signed [CW-1:0]    mul_a;
    logic signed [CW-1:0]    mul_b;
    logic signed [2*CW-1:0]  mul_p;
    logic signed [CW-1:0]    mul_q;
    logic signed [CW-1:0]    sum;
    logic [61:0]             sq_bit;
    logic [61:0]             sq_trial;
    logic [61:0]             root_next;
    logic [61:0]             n_next;
    logic signed [CW-1:0]    z_fin;
    logic [47:0]             miles_p;
    logic [34:0]             div_p;

    assign {e_valid, e_slat, e_tlat, e_dlon} = mid_data;

    always_comb
    begin
        wrap_thr = FULL_DEG <<< k_reg;
        wrapped  = (r_reg >= HALF_DEG) ? r_reg - FULL_DEG : r_reg;
        folded   = wrapped;
        fold_flip = 1'b0;
        if (wrapped > QUAR_DEG)
        begin
            folded    = wrapped - HALF_DEG;
            fold_flip = 1'b1;
        end
        else if (wrapped < -QUAR_DEG)
        begin
            folded    = wrapped + HALF_DEG;
            fold_flip = 1'b1;
        end

        dir    = (state_reg == S_ROT) ? !z_reg[CW-1] : y_reg[CW-1];
        xs     = x_reg >>> cnt_reg;
        ys     = y_reg >>> cnt_reg;
        atan_v = $signed({{(CW-32){1'b0}}, ATAN_TAB[5'(cnt_reg)]});
        x_step = dir ? x_reg - ys : x_reg + ys;
        y_step = dir ? y_reg + xs : y_reg - xs;
        z_step = dir ? z_reg - atan_v : z_reg + atan_v;

        case (state_reg)
            S_MUL_A:
            begin
                mul_a = s_reg[0];
                mul_b = s_reg[1];
            end
            S_MUL_B1:
            begin
                mul_a = c_reg[0];
                mul_b = c_reg[1];
            end
            S_MUL_B2:
            begin
                mul_a = b_reg;
                mul_b = c_reg[2];
            end
            S_SQ:
            begin
                mul_a = arg_reg;
                mul_b = arg_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
        mul_q = CW'(mul_p >>> 30);

        sum = a_reg + b_reg;

        sq_bit    = 62'd1 << {p_reg, 1'b0};
        sq_trial  = root_reg + sq_bit;
        root_next = (n_reg >= sq_trial) ? (root_reg >> 1) + sq_bit : root_reg >> 1;
        n_next    = (n_reg >= sq_trial) ? n_reg - sq_trial : n_reg;

        z_fin = arg_reg[CW-1] ? PI_S - z_reg : z_reg;

        miles_p = 48'(ang_reg) * 48'd39588;
        div_p   = 35'(v_reg) * 35'd209716;
    end

    assign mid_pop  = (state_reg == S_IDLE) && !mid_empty;
    assign out_push = (state_reg == S_DONE) && !out_full;
    assign out_item.distance_miles = dist_reg;
    assign out_item.locator_valid  = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            cnt_reg   <= '0;
            sel_reg   <= '0;
            p_reg     <= '0;
            valid_reg <= 1'b0;
            dist_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!mid_empty)
                    begin
                        valid_reg <= e_valid;
                        tlat_reg  <= e_tlat;
                        dlon_reg  <= e_dlon;
                        r_reg     <= e_slat + BIAS_DEG;
                        k_reg     <= 3'd5;
                        sel_reg   <= '0;
                        dist_reg  <= '0;
                        state_reg <= e_valid ? S_WRAP : S_DONE;
                    end
                end
                S_WRAP:
                begin
                    if (r_reg >= wrap_thr)
                    begin
                        r_reg <= r_reg - wrap_thr;
                    end
                    if (k_reg == '0)
                    begin
                        state_reg <= S_FOLD;
                    end
                    else
                    begin
                        k_reg <= k_reg - 1'b1;
                    end
                end
                S_FOLD:
                begin
                    fa_reg    <= AW'(folded);
                    flip_reg  <= fold_flip;
                    state_reg <= S_CONV;
                end
                S_CONV:
                begin
                    prod_reg  <= PW'(fa_reg) * PW'(D2R);
                    state_reg <= S_ZINIT;
                end
                S_ZINIT:
                begin
                    x_reg     <= GAIN;
                    y_reg     <= '0;
                    z_reg     <= CW'(prod_reg >>> (ANGLE_FRAC_BITS + 2));
                    cnt_reg   <= '0;
                    state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    x_reg <= x_step;
                    y_reg <= y_step;
                    z_reg <= z_step;
                    if (cnt_reg == SW'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= S_STORE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_STORE:
                begin
                    s_reg[sel_reg] <= flip_reg ? -y_reg : y_reg;
                    c_reg[sel_reg] <= flip_reg ? -x_reg : x_reg;
                    if (sel_reg == 2'd2)
                    begin
                        state_reg <= S_MUL_A;
                    end
                    else
                    begin
                        r_reg     <= ((sel_reg == 2'd0) ? tlat_reg : dlon_reg) + BIAS_DEG;
                        k_reg     <= 3'd5;
                        sel_reg   <= sel_reg + 1'b1;
                        state_reg <= S_WRAP;
                    end
                end
                S_MUL_A:
                begin
                    a_reg     <= mul_q;
                    state_reg <= S_MUL_B1;
                end
                S_MUL_B1:
                begin
                    b_reg     <= mul_q;
                    state_reg <= S_MUL_B2;
                end
                S_MUL_B2:
                begin
                    b_reg     <= mul_q;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (sum > ONE)
                    begin
                        arg_reg <= ONE;
                    end
                    else if (sum < -ONE)
                    begin
                        arg_reg <= -ONE;
                    end
                    else
                    begin
                        arg_reg <= sum;
                    end
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    n_reg     <= (62'd1 << 60) - 62'(mul_p);
                    root_reg  <= '0;
                    p_reg     <= 5'd30;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    n_reg    <= n_next;
                    root_reg <= root_next;
                    if (p_reg == '0)
                    begin
                        x_reg     <= arg_reg[CW-1] ? -arg_reg : arg_reg;
                        y_reg     <= CW'(root_next);
                        z_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_VEC;
                    end
                    else
                    begin
                        p_reg <= p_reg - 1'b1;
                    end
                end
                S_VEC:
                begin
                    x_reg <= x_step;
                    y_reg <= y_step;
                    z_reg <= z_step;
                    if (cnt_reg == SW'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= S_ANG;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_ANG:
                begin
                    if (z_fin[CW-1])
                    begin
                        ang_reg <= '0;
                    end
                    else if (z_fin > PI_S)
                    begin
                        ang_reg <= 32'(PI_S);
                    end
                    else
                    begin
                        ang_reg <= 32'(z_fin);
                    end
                    state_reg <= S_MILES;
                end
                S_MILES:
                begin
                    v_reg     <= miles_p[46:30];
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    dist_reg  <= div_p[34:21];
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `LGCD_ASSERT(invalid_gives_zero, out_push && !valid_reg |-> dist_reg == '0)
    `LGCD_ASSERT(pop_only_idle, mid_pop |-> state_reg == S_IDLE)
    `LGCD_ASSERT(step_count_bound, cnt_reg <= SW'(CORDIC_STEPS - 1))

endmodule

FILE: design/locator_great_circle_distance.sv
// ----------------------------------------------------------------------------
// locator_great_circle_distance
// Great-circle distance in miles from a station grid locator to a target.
// ----------------------------------------------------------------------------
// Targets enter on a queue-style port: the four ASCII characters are taken
// with push while full is low. Results leave the same way: while empty is
// low the oldest result is on result, and pop takes it.
// The station locator lives in four registers written over the cfg port
// (index 0..3, low 8 bits of data); cfg_ready is always high.
// The front checks and decodes each target in the cycle it is taken and
// places it in a four-entry queue, so four targets are taken back to back.
// The back runs one item at a time through a single shared CORDIC,
// multiplier and square-root unit and pops the next item only once the
// last is in the result queue, which sets the sustained rate; an invalid
// target skips the arithmetic and leaves with distance zero. A two-entry
// result queue lets the back finish while the receiver stalls; once it
// is full the back waits and the input queue fills up until full rises.
// Reset clears both queues and sets the station to AA00.
// ----------------------------------------------------------------------------
module locator_great_circle_distance #(
    parameter int CORDIC_STEPS    = lgcd_pkg::DEF_CORDIC_STEPS,
    parameter int ANGLE_FRAC_BITS = lgcd_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lgcd_pkg::target_t  target,
    output logic               empty,
    input  logic               pop,
    output lgcd_pkg::result_t  result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import lgcd_pkg::*;

    localparam int DEG_W   = ANGLE_FRAC_BITS + 16;
    localparam int ENTRY_W = 3 * DEG_W + 1;

    logic               mid_push;
    logic               mid_full;
    logic               mid_pop;
    logic               mid_empty;
    logic [ENTRY_W-1:0] mid_wdata;
    logic [ENTRY_W-1:0] mid_rdata;
    logic               out_push;
    logic               out_full;
    result_t            out_item;
    logic [$bits(result_t)-1:0] out_rdata;

    assign full   = mid_full;
    assign result = result_t'(out_rdata);

    lgcd_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .DEG_W           (DEG_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .target    (target),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mid_full  (mid_full),
        .mid_push  (mid_push),
        .mid_data  (mid_wdata)
    );

    lgcd_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (4)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    lgcd_back #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .DEG_W           (DEG_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_data  (mid_rdata),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (out_item)
    );

    lgcd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_item),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Locator distance testbench
// Sends target grid locators through the queue-style port, predicts the
// validity flag and the great-circle distance in miles with a fixed-point
// CORDIC model of its own, and compares every result popped from the block.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lgcd_pkg::*;

    localparam int STEPS = 24;
    localparam int FRAC  = 20;
    localparam longint DEG1 = longint'(1) << FRAC;
    localparam longint ONE30 = longint'(1) << 30;
    localparam longint CYCLE_LIMIT = 3000000;

    class distance_scoreboard;
        result_t expected_q[$];
        logic [7:0] station [0:3];
        int mismatches;
        int targets_seen;
        int valid_seen;
        longint atan_q [0:31];

        function new();
            longint unsigned acc, term;
            station[0] = CHAR_A;
            station[1] = CHAR_A;
            station[2] = CHAR_ZERO;
            station[3] = CHAR_ZERO;
            mismatches = 0;
            targets_seen = 0;
            valid_seen = 0;
            for (int i = 0; i < 32; i++)
            begin
                if (i == 0)
                begin
                    atan_q[i] = longint'((PI_Q60 + (64'd1 << 31)) >> 32);
                end
                else
                begin
                    acc = 0;
                    for (int k = 0; 62 >= i * (2 * k + 1); k++)
                    begin
                        term = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
                        acc = k[0] ? acc - term : acc + term;
                    end
                    atan_q[i] = longint'((acc + (64'd1 << 31)) >> 32);
                end
            end
        endfunction

        function longint wrap360(longint a);
            longint r;
            r = a % (360 * DEG1);
            if (r < 0)
                r += 360 * DEG1;
            if (r >= 180 * DEG1)
                r -= 360 * DEG1;
            return r;
        endfunction

        function void sine_cosine(longint deg, output longint s, output longint c);
            longint a, x, y, z, xs, ys;
            bit flip;
            a = wrap360(deg);
            flip = 0;
            x = longint'(GAIN_INV_Q30);
            y = 0;
            if (a > 90 * DEG1)
            begin
                a -= 180 * DEG1;
                flip = 1;
            end
            else if (a < -90 * DEG1)
            begin
                a += 180 * DEG1;
                flip = 1;
            end
            z = (a * longint'(DEG2RAD_Q32)) >>> (FRAC + 2);
            for (int i = 0; i < STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x -= ys; y += xs; z -= atan_q[i];
                end
                else
                begin
                    x += ys; y -= xs; z += atan_q[i];
                end
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint arc_cosine(longint t);
            longint x, y, z, xs, ys;
            x = t < 0 ? -t : t;
            y = longint'(int_sqrt(longint'(ONE30 * ONE30) - t * t));
            z = 0;
            for (int i = 0; i < STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x += ys; y -= xs; z += atan_q[i];
                end
                else
                begin
                    x -= ys; y += xs; z -= atan_q[i];
                end
            end
            if (t < 0)
                z = longint'(PI_Q30) - z;
            if (z < 0)
                z = 0;
            if (z > longint'(PI_Q30))
                z = longint'(PI_Q30);
            return z;
        endfunction

        function void grid_to_degrees(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                      logic [7:0] c3, output longint lat,
                                      output longint lon);
            logic [7:0] l1, l2, d1, d2;
            l1 = c0 - CHAR_A;
            l2 = c1 - CHAR_A;
            d1 = c2 - CHAR_ZERO;
            d2 = c3 - CHAR_ZERO;
            lat = (longint'(l2) * 10 + longint'(d2) - 90) * DEG1 + (23 * DEG1 + 24) / 48;
            lon = (longint'(l1) * 20 + longint'(d1) * 2 - 180) * DEG1
                  + (23 * DEG1 + 12) / 24;
        endfunction

        function void note_target(target_t t);
            result_t r;
            longint slat, slon, tlat, tlon, s1, c1, s2, c2, sd, cd, a, b, arg, ang;
            longint unsigned miles;
            r.locator_valid = t.target_lon_field_char >= LON_FIRST
                && t.target_lon_field_char <= LON_LAST
                && t.target_lat_field_char >= LAT_FIRST
                && t.target_lat_field_char <= LAT_LAST
                && t.target_lon_square_char >= CHAR_ZERO
                && t.target_lon_square_char <= DIGIT_LAST
                && t.target_lat_square_char >= CHAR_ZERO
                && t.target_lat_square_char <= DIGIT_LAST;
            miles = 0;
            if (r.locator_valid)
            begin
                grid_to_degrees(station[0], station[1], station[2], station[3], slat, slon);
                grid_to_degrees(t.target_lon_field_char, t.target_lat_field_char,
                                t.target_lon_square_char, t.target_lat_square_char,
                                tlat, tlon);
                sine_cosine(slat, s1, c1);
                sine_cosine(tlat, s2, c2);
                sine_cosine(wrap360(tlon - slon), sd, cd);
                a = (s1 * s2) >>> 30;
                b = (c1 * c2) >>> 30;
                b = (b * cd) >>> 30;
                arg = a + b;
                if (arg > ONE30)
                    arg = ONE30;
                if (arg < -ONE30)
                    arg = -ONE30;
                ang = arc_cosine(arg);
                miles = (longint'(ang) * 39588) / (longint'(10) << 30);
                valid_seen++;
            end
            r.distance_miles = miles[13:0];
            expected_q.push_back(r);
            targets_seen++;
        endfunction

        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result with nothing expected", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.locator_valid !== want.locator_valid)
                report_mismatch("locator_valid", want, got);
            if (got.distance_miles !== want.distance_miles)
                report_mismatch("distance_miles", want, got);
        endtask

        task report_mismatch(string what, result_t want, result_t got);
            mismatches++;
            $display("mismatch %s: expected %0d/%0d got %0d/%0d", what,
                     want.distance_miles, want.locator_valid,
                     got.distance_miles, got.locator_valid);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    target_t target;
    logic empty;
    logic pop;
    result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [7:0] cfg_index;
    logic [7:0] cfg_data;

    distance_scoreboard board;
    int send_idle_pct;
    int pop_stall_pct;
    longint cycles;
    int config_writes;

    locator_great_circle_distance uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .target(target),
        .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
        clk = 0;
    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                board.check_result(result);
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    task automatic send_target(target_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 0;
            @(posedge clk);
        end
        push <= 1;
        target <= t;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_target(t);
    endtask

    task automatic wait_drained();
        push <= 0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic write_station(cfg_index_t idx, logic [7:0] value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.station[idx] = value;
        config_writes++;
    endtask

    task automatic set_station(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                               logic [7:0] c3);
        wait_drained();
        write_station(CFG_LON_FIELD, c0);
        write_station(CFG_LAT_FIELD, c1);
        write_station(CFG_LON_SQUARE, c2);
        write_station(CFG_LAT_SQUARE, c3);
        cfg_valid <= 0;
    endtask

    function automatic target_t random_target();
        target_t t;
        int kind;
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            t.target_lon_field_char = 8'($urandom_range(LON_LAST, LON_FIRST));
            t.target_lat_field_char = 8'($urandom_range(LAT_LAST, LAT_FIRST));
            t.target_lon_square_char = 8'($urandom_range(DIGIT_LAST, CHAR_ZERO));
            t.target_lat_square_char = 8'($urandom_range(DIGIT_LAST, CHAR_ZERO));
            if (kind < 15)
            begin
                case ($urandom_range(3))
                    0: t.target_lon_field_char = 8'($urandom_range(255));
                    1: t.target_lat_field_char = 8'($urandom_range(255));
                    2: t.target_lon_square_char = 8'($urandom_range(255));
                    default: t.target_lat_square_char = 8'($urandom_range(255));
                endcase
            end
        end
        else
            t = $urandom;
        return t;
    endfunction

    task automatic run_phase(int count, int idle, int stall);
        send_idle_pct = idle;
        pop_stall_pct = stall;
        for (int n = 0; n < count; n++)
            send_target(random_target());
    endtask

    initial
    begin
        target_t t;
        board = new();
        cycles = 0;
        config_writes = 0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        rst_n = 0;
        push = 0;
        pop = 0;
        target = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: field edges, blocked polar rows, invalid digits, poles of the grid.
        send_target({8'd65, 8'd66, 8'd48, 8'd48});
        send_target({8'd82, 8'd81, 8'd57, 8'd57});
        send_target({8'd65, 8'd65, 8'd48, 8'd48});
        send_target({8'd82, 8'd82, 8'd57, 8'd57});
        send_target({8'd64, 8'd70, 8'd52, 8'd52});
        send_target({8'd83, 8'd70, 8'd52, 8'd52});
        send_target({8'd70, 8'd70, 8'd47, 8'd52});
        send_target({8'd70, 8'd70, 8'd52, 8'd58});
        send_target({8'd0, 8'd0, 8'd0, 8'd0});
        send_target({8'd255, 8'd255, 8'd255, 8'd255});
        send_target({8'd74, 8'd74, 8'd48, 8'd48});
        send_target({8'd65, 8'd74, 8'd48, 8'd48});
        set_station(8'd82, 8'd81, 8'd57, 8'd57);
        send_target({8'd82, 8'd81, 8'd57, 8'd57});
        send_target({8'd65, 8'd66, 8'd48, 8'd48});
        send_target({8'd73, 8'd73, 8'd57, 8'd57});
        set_station(8'd74, 8'd74, 8'd48, 8'd48);
        send_target({8'd74, 8'd74, 8'd48, 8'd48});
        send_target({8'd65, 8'd74, 8'd48, 8'd48});
        set_station(8'd0, 8'd255, 8'd255, 8'd0);
        send_target({8'd70, 8'd75, 8'd53, 8'd51});
        send_target({8'd81, 8'd66, 8'd49, 8'd56});

        run_phase(300, 0, 0);
        set_station(8'd70, 8'd78, 8'd52, 8'd49);
        run_phase(250, 85, 0);
        set_station(8'd65, 8'd65, 8'd48, 8'd48);
        run_phase(250, 0, 85);
        set_station(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_phase(200, 34, 34);
        wait_drained();
        set_station(8'($urandom_range(LON_LAST, LON_FIRST)),
                    8'($urandom_range(LAT_LAST, LAT_FIRST)),
                    8'($urandom_range(DIGIT_LAST, CHAR_ZERO)),
                    8'($urandom_range(DIGIT_LAST, CHAR_ZERO)));
        run_phase(300, 0, 0);
        set_station(8'd82, 8'd66, 8'd48, 8'd57);
        run_phase(300, 34, 34);

        push <= 0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (400)
            @(posedge clk);
        $display("covered %0d targets (%0d valid) and %0d station register writes",
                 board.targets_seen, board.valid_seen, config_writes);
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: locator_great_circle_distance.f
+incdir+design
design/lgcd_pkg.sv
design/lgcd_fifo.sv
design/lgcd_front.sv
design/lgcd_back.sv
design/locator_great_circle_distance.sv
dv/testbench.sv
